// ----- hdl/uhas_pkg.sv -----
// Package for the USB host attach sequencer: item and result layouts,
// phase and action codes, and the configuration register set.
// No dependencies; every module of the block imports it.
package uhas_pkg;

    localparam int TIMER_WIDTH = 24;
    localparam int CFG_WIDTH   = 24;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int S_DATA_WIDTH  = 16;
    localparam int M_DATA_WIDTH  = 8;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    localparam logic [7:0] VBUS_MASK   = 8'hC0;
    localparam logic [7:0] VBUS_VALID  = 8'hC0;
    localparam logic [7:0] VBUS_AVALID = 8'h80;
    localparam logic [7:0] FS_DEVICE   = 8'h10;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_RAMP_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_AVALID_WARN    = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DETECT_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RESET_HOLD     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RECOVERY       = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ERROR_RETRY    = 3'd5;

    localparam logic [CFG_WIDTH-1:0] RST_RAMP_TIMEOUT   = 24'd500000;
    localparam logic [CFG_WIDTH-1:0] RST_AVALID_WARN    = 24'd100000;
    localparam logic [CFG_WIDTH-1:0] RST_DETECT_TIMEOUT = 24'd1000000;
    localparam logic [CFG_WIDTH-1:0] RST_RESET_HOLD     = 24'd50000;
    localparam logic [CFG_WIDTH-1:0] RST_RECOVERY       = 24'd60000;
    localparam logic [CFG_WIDTH-1:0] RST_ERROR_RETRY    = 24'd2000000;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_POWER_ON  = 3'd1;
    localparam logic [2:0] ACT_RESET_ON  = 3'd2;
    localparam logic [2:0] ACT_RESET_OFF = 3'd3;
    localparam logic [2:0] ACT_CONFIG    = 3'd4;
    localparam logic [2:0] ACT_POWER_OFF = 3'd5;

    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_RAMP       = 3'd1;
    localparam logic [2:0] CODE_DETECT     = 3'd2;
    localparam logic [2:0] CODE_RESET_WAIT = 3'd3;
    localparam logic [2:0] CODE_READY      = 3'd4;
    localparam logic [2:0] CODE_ERROR      = 3'd5;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_RAMP       = 6'b000010,
        PH_DETECT     = 6'b000100,
        PH_RESET_WAIT = 6'b001000,
        PH_READY      = 6'b010000,
        PH_ERROR      = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       disconnect_event;
        logic       connect_event;
        logic [7:0] device_control;
    } item_t;

    typedef struct packed {
        logic       avalid_warning;
        logic       link_active;
        logic [2:0] fsm_state;
        logic [2:0] action;
    } result_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] ramp_timeout;
        logic [CFG_WIDTH-1:0] avalid_warn_ticks;
        logic [CFG_WIDTH-1:0] detect_timeout;
        logic [CFG_WIDTH-1:0] reset_hold_ticks;
        logic [CFG_WIDTH-1:0] recovery_ticks;
        logic [CFG_WIDTH-1:0] error_retry_ticks;
    } cfg_t;

    function automatic logic [2:0] phase_code(phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:       code = CODE_IDLE;
            PH_RAMP:       code = CODE_RAMP;
            PH_DETECT:     code = CODE_DETECT;
            PH_RESET_WAIT: code = CODE_RESET_WAIT;
            PH_READY:      code = CODE_READY;
            PH_ERROR:      code = CODE_ERROR;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/uhas_cfg_regs.sv -----
// Configuration register file of the USB host attach sequencer.
// Takes one register write per request; depends on uhas_pkg.
module uhas_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uhas_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [uhas_pkg::CFG_WIDTH-1:0]   cfg_data,
    output uhas_pkg::cfg_t                   cfg
);
    import uhas_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ramp_timeout      <= RST_RAMP_TIMEOUT;
            cfg_reg.avalid_warn_ticks <= RST_AVALID_WARN;
            cfg_reg.detect_timeout    <= RST_DETECT_TIMEOUT;
            cfg_reg.reset_hold_ticks  <= RST_RESET_HOLD;
            cfg_reg.recovery_ticks    <= RST_RECOVERY;
            cfg_reg.error_retry_ticks <= RST_ERROR_RETRY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RAMP_TIMEOUT:   cfg_reg.ramp_timeout      <= cfg_data;
                REG_AVALID_WARN:    cfg_reg.avalid_warn_ticks <= cfg_data;
                REG_DETECT_TIMEOUT: cfg_reg.detect_timeout    <= cfg_data;
                REG_RESET_HOLD:     cfg_reg.reset_hold_ticks  <= cfg_data;
                REG_RECOVERY:       cfg_reg.recovery_ticks    <= cfg_data;
                REG_ERROR_RETRY:    cfg_reg.error_retry_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/uhas_step.sv -----
// Next-state and result logic for one poll tick of the attach sequencer.
// Purely combinational; depends on uhas_pkg.
module uhas_step (
    input  uhas_pkg::item_t                     item,
    input  uhas_pkg::phase_t                    phase,
    input  logic [uhas_pkg::TIMER_WIDTH-1:0]    tick,
    input  logic                                active,
    input  uhas_pkg::cfg_t                      cfg,
    output uhas_pkg::phase_t                    phase_next,
    output logic [uhas_pkg::TIMER_WIDTH-1:0]    tick_next,
    output logic                                active_next,
    output uhas_pkg::result_t                   res
);
    import uhas_pkg::*;

    logic                   vbus_valid;
    logic                   vbus_avalid;
    logic                   fsdev;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic [CMP_WIDTH-1:0]   cnt_x;
    logic [2:0]             action;
    logic                   warn;

    assign vbus_valid  = (item.device_control & VBUS_MASK) == VBUS_VALID;
    assign vbus_avalid = (item.device_control & VBUS_MASK) == VBUS_AVALID;
    assign fsdev       = (item.device_control & FS_DEVICE) != 8'h00;
    assign tick_inc    = (tick == TIMER_MAX) ? tick : tick + 1'b1;
    assign cnt_x       = CMP_WIDTH'(tick_inc);

    always_comb begin
        phase_next  = phase;
        tick_next   = tick;
        active_next = active;
        action      = ACT_NONE;
        warn        = 1'b0;
        if (item.disconnect_event && (phase == PH_READY || phase == PH_ERROR)) begin
            active_next = 1'b0;
            phase_next  = PH_IDLE;
            tick_next   = '0;
            action      = ACT_POWER_OFF;
        end else begin
            unique case (phase)
                PH_IDLE: begin
                    action     = ACT_POWER_ON;
                    phase_next = PH_RAMP;
                    tick_next  = '0;
                end
                PH_RAMP: begin
                    if (vbus_valid) begin
                        phase_next = PH_DETECT;
                        tick_next  = '0;
                    end else if (vbus_avalid && fsdev) begin
                        tick_next = tick_inc;
                        warn      = cnt_x > CMP_WIDTH'(cfg.avalid_warn_ticks);
                    end else if (cnt_x > CMP_WIDTH'(cfg.ramp_timeout)) begin
                        phase_next = PH_ERROR;
                        tick_next  = '0;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                PH_DETECT: begin
                    if (fsdev || item.connect_event) begin
                        action     = ACT_RESET_ON;
                        tick_next  = '0;
                        phase_next = PH_RESET_WAIT;
                    end else if (cnt_x > CMP_WIDTH'(cfg.detect_timeout)) begin
                        tick_next  = '0;
                        phase_next = PH_RAMP;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                PH_RESET_WAIT: begin
                    tick_next = tick_inc;
                    if (cnt_x == CMP_WIDTH'(cfg.reset_hold_ticks)) begin
                        action = ACT_RESET_OFF;
                    end else if (cnt_x >= CMP_WIDTH'(cfg.recovery_ticks)) begin
                        action      = ACT_CONFIG;
                        active_next = 1'b1;
                        phase_next  = PH_READY;
                        tick_next   = '0;
                    end
                end
                PH_READY: begin
                end
                PH_ERROR: begin
                    if (cnt_x > CMP_WIDTH'(cfg.error_retry_ticks)) begin
                        active_next = 1'b0;
                        phase_next  = PH_IDLE;
                        tick_next   = '0;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end
    end

    assign res.action         = action;
    assign res.fsm_state      = phase_code(phase_next);
    assign res.link_active    = active_next;
    assign res.avalid_warning = warn;

endmodule

// ----- hdl/usb_host_attach_sequencer.sv -----
// USB host attach sequencer: top level with input register, sequencer
// state and result register. Depends on uhas_pkg, uhas_cfg_regs, uhas_step.
//
// Each request on the s_ channel is one poll tick. It is held in an input
// register, then combinational logic advances the attach sequence (idle,
// VBUS ramp, device detect, bus reset wait, ready, error) and writes one
// result into the output register presented on the m_ channel.
// A request passes from the input register to the output register and
// m_tvalid; one request is taken every cycle while the receiver does not stall.
// The cfg_ channel writes the six timing limits; cfg_ready is always high
// and writes are meant to happen only while the block is idle.
// A synchronous low on aresetn empties both registers, returns the
// sequence to idle with a cleared timer and link flag, and restores the
// default limits.
// When m_tready is low the result is held; the input register still takes
// one more request, after which s_tready falls until the result is taken.
module usb_host_attach_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // device_control[7:0], connect_event[8], disconnect_event[9], zeros
    input  logic [uhas_pkg::S_DATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // action[2:0], fsm_state[5:3], link_active[6], avalid_warning[7]
    output logic [uhas_pkg::M_DATA_WIDTH-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uhas_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [uhas_pkg::CFG_WIDTH-1:0]      cfg_data
);
    import uhas_pkg::*;

    cfg_t                   cfg;
    logic                   in_valid_reg;
    item_t                  in_item_reg;
    logic                   out_valid_reg;
    result_t                out_res_reg;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TIMER_WIDTH-1:0] tick_reg;
    logic [TIMER_WIDTH-1:0] tick_next;
    logic                   active_reg;
    logic                   active_next;
    result_t                res;
    logic                   advance;

    uhas_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uhas_step u_step (
        .item        (in_item_reg),
        .phase       (phase_reg),
        .tick        (tick_reg),
        .active      (active_reg),
        .cfg         (cfg),
        .phase_next  (phase_next),
        .tick_next   (tick_next),
        .active_next (active_next),
        .res         (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            active_reg    <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                active_reg    <= active_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

endmodule

// ----- hdl/uhas_checker.sv -----
// Port-level checks for the USB host attach sequencer, bound to the top.
// Depends on uhas_pkg and usb_host_attach_sequencer.
module uhas_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [uhas_pkg::M_DATA_WIDTH-1:0]   m_tdata
);
    import uhas_pkg::*;

    result_t r;

    assign r = result_t'(m_tdata);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_config_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.action == ACT_CONFIG |-> r.fsm_state == CODE_READY && r.link_active)
        else $error("pipe configuration without ready and active link");

    a_power_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.action == ACT_POWER_OFF |-> r.fsm_state == CODE_IDLE && !r.link_active)
        else $error("power off without return to idle");

    a_warn_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.avalid_warning |-> r.fsm_state == CODE_RAMP && r.action == ACT_NONE)
        else $error("AValid warning outside VBUS ramp");

endmodule

bind usb_host_attach_sequencer uhas_checker u_uhas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/usb_host_attach_sequencer_tb.sv -----
// Self-checking testbench for usb_host_attach_sequencer: a directed table of
// poll ticks, then randomized attach sequences under several limit settings.
// Depends on uhas_pkg and the block's RTL.
`timescale 1ns / 1ps

module usb_host_attach_sequencer_tb;
    import uhas_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD = 60;
    localparam int POLLS_PER_SETTING = 55;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        item_t   poll;
        bit      fixed;
        result_t want;
    } poll_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_WIDTH-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_WIDTH-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0] cfg_data = '0;

    // Predicted sequencer state and limits, as after reset.
    logic [2:0] seq_phase = CODE_IDLE;
    logic [TIMER_WIDTH-1:0] seq_ticks = '0;
    logic seq_active = 1'b0;
    cfg_t limits = '{ramp_timeout: RST_RAMP_TIMEOUT, avalid_warn_ticks: RST_AVALID_WARN,
                     detect_timeout: RST_DETECT_TIMEOUT, reset_hold_ticks: RST_RESET_HOLD,
                     recovery_ticks: RST_RECOVERY, error_retry_ticks: RST_ERROR_RETRY};

    result_t status_due[$];
    poll_row_t directed_polls[$];
    int mismatches = 0;
    int cycle_count = 0;
    bit src_quiet = 1'b0;
    bit dst_quiet = 1'b0;
    bit hold_burst = 1'b0;

    usb_host_attach_sequencer dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[usb_host_attach_sequencer] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void count_tick();
        if (seq_ticks != TIMER_MAX)
            seq_ticks = seq_ticks + 1'b1;
    endfunction

    function automatic result_t advance_attach(input item_t poll);
        result_t r;
        logic [7:0] vbus;
        logic fs_dev;
        vbus = poll.device_control & VBUS_MASK;
        fs_dev = (poll.device_control & FS_DEVICE) != 0;
        r.action = ACT_NONE;
        r.avalid_warning = 1'b0;
        if (poll.disconnect_event && (seq_phase == CODE_READY || seq_phase == CODE_ERROR)) begin
            seq_active = 1'b0;
            seq_phase = CODE_IDLE;
            seq_ticks = '0;
            r.action = ACT_POWER_OFF;
        end else begin
            case (seq_phase)
                CODE_IDLE: begin
                    r.action = ACT_POWER_ON;
                    seq_phase = CODE_RAMP;
                    seq_ticks = '0;
                end
                CODE_RAMP: begin
                    if (vbus == VBUS_VALID) begin
                        seq_phase = CODE_DETECT;
                        seq_ticks = '0;
                    end else if (vbus == VBUS_AVALID && fs_dev) begin
                        count_tick();
                        if (seq_ticks > limits.avalid_warn_ticks)
                            r.avalid_warning = 1'b1;
                    end else begin
                        count_tick();
                        if (seq_ticks > limits.ramp_timeout) begin
                            seq_phase = CODE_ERROR;
                            seq_ticks = '0;
                        end
                    end
                end
                CODE_DETECT: begin
                    if (fs_dev || poll.connect_event) begin
                        r.action = ACT_RESET_ON;
                        seq_ticks = '0;
                        seq_phase = CODE_RESET_WAIT;
                    end else begin
                        count_tick();
                        if (seq_ticks > limits.detect_timeout) begin
                            seq_ticks = '0;
                            seq_phase = CODE_RAMP;
                        end
                    end
                end
                CODE_RESET_WAIT: begin
                    count_tick();
                    if (seq_ticks == limits.reset_hold_ticks) begin
                        r.action = ACT_RESET_OFF;
                    end else if (seq_ticks >= limits.recovery_ticks) begin
                        r.action = ACT_CONFIG;
                        seq_active = 1'b1;
                        seq_phase = CODE_READY;
                        seq_ticks = '0;
                    end
                end
                CODE_READY: begin
                end
                CODE_ERROR: begin
                    count_tick();
                    if (seq_ticks > limits.error_retry_ticks) begin
                        seq_active = 1'b0;
                        seq_phase = CODE_IDLE;
                        seq_ticks = '0;
                    end
                end
                default: begin
                    seq_phase = CODE_IDLE;
                    seq_ticks = '0;
                end
            endcase
        end
        r.fsm_state = seq_phase;
        r.link_active = seq_active;
        return r;
    endfunction

    // Mostly well-formed traffic for the predicted state, with some noise.
    function automatic item_t next_poll();
        item_t poll;
        int pick;
        poll = item_t'($urandom_range(0, 1023));
        poll.connect_event = ($urandom_range(0, 9) == 0);
        poll.disconnect_event = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 99) < 15)
            return item_t'($urandom_range(0, 1023));
        pick = $urandom_range(0, 99);
        case (seq_phase)
            CODE_RAMP: begin
                if (pick < 25) begin
                    poll.device_control[7:6] = 2'b11;
                end else if (pick < 60) begin
                    poll.device_control[7:6] = 2'b10;
                    poll.device_control[4] = 1'b1;
                end else begin
                    poll.device_control[7:6] = 2'($urandom_range(0, 2));
                end
            end
            CODE_DETECT: begin
                if (pick < 75) begin
                    poll.device_control[4] = 1'b0;
                    poll.connect_event = 1'b0;
                end
            end
            CODE_READY, CODE_ERROR: begin
                poll.disconnect_event = (pick < 25);
            end
            default: begin
            end
        endcase
        return poll;
    endfunction

    function automatic int draw_gap(input bit quiet);
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic add_row(input logic [7:0] dc, input bit conn, input bit disc,
                           input bit fixed, input logic [2:0] act, input logic [2:0] st,
                           input bit lnk, input bit wrn);
        poll_row_t row;
        row.poll = '{disconnect_event: disc, connect_event: conn, device_control: dc};
        row.fixed = fixed;
        row.want = '{avalid_warning: wrn, link_active: lnk, fsm_state: st, action: act};
        directed_polls.push_back(row);
    endtask

    task automatic offer_poll(input item_t poll, input bit fixed, input result_t want);
        int gap;
        result_t predicted;
        gap = draw_gap(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_WIDTH - $bits(item_t)){1'b0}}, poll};
        do @(posedge aclk); while (!s_tready);
        predicted = advance_attach(poll);
        status_due.push_back(fixed ? want : predicted);
    endtask

    task automatic put_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RAMP_TIMEOUT:   limits.ramp_timeout = val;
            REG_AVALID_WARN:    limits.avalid_warn_ticks = val;
            REG_DETECT_TIMEOUT: limits.detect_timeout = val;
            REG_RESET_HOLD:     limits.reset_hold_ticks = val;
            REG_RECOVERY:       limits.recovery_ticks = val;
            REG_ERROR_RETRY:    limits.error_retry_ticks = val;
            default: begin
            end
        endcase
    endtask

    task automatic load_limits(input cfg_t c);
        put_reg(REG_RAMP_TIMEOUT, c.ramp_timeout);
        put_reg(REG_AVALID_WARN, c.avalid_warn_ticks);
        put_reg(REG_DETECT_TIMEOUT, c.detect_timeout);
        put_reg(REG_RESET_HOLD, c.reset_hold_ticks);
        put_reg(REG_RECOVERY, c.recovery_ticks);
        put_reg(REG_ERROR_RETRY, c.error_retry_ticks);
        put_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_WIDTH'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        int gap;
        result_t got;
        result_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_burst) begin
                hold_burst = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = draw_gap(dst_quiet);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = result_t'(m_tdata);
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("unexpected status 0x%02h", m_tdata));
            end else begin
                want = status_due.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, expected %0d",
                                              got.action, want.action));
                if (got.fsm_state !== want.fsm_state)
                    report_mismatch($sformatf("fsm_state %0d, expected %0d",
                                              got.fsm_state, want.fsm_state));
                if (got.link_active !== want.link_active)
                    report_mismatch($sformatf("link_active %b, expected %b",
                                              got.link_active, want.link_active));
                if (got.avalid_warning !== want.avalid_warning)
                    report_mismatch($sformatf("avalid_warning %b, expected %b",
                                              got.avalid_warning, want.avalid_warning));
            end
        end
    end

    initial begin
        cfg_t c;
        int k;
        int n;
        // Short limits so that every timeout fires within a few polls.
        add_row(8'h00, 0, 0, 1, ACT_POWER_ON, CODE_RAMP, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h90, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h90, 0, 0, 1, ACT_NONE, CODE_RAMP, 0, 1);
        add_row(8'hC0, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h0F, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h2F, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'hFF, 0, 1, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 1, 0, 1, ACT_RESET_ON, CODE_RESET_WAIT, 0, 0);
        add_row(8'hFF, 1, 1, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 1, ACT_RESET_OFF, CODE_RESET_WAIT, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 1, ACT_CONFIG, CODE_READY, 1, 0);
        add_row(8'hFF, 1, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 1, 1, ACT_POWER_OFF, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 1, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h40, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h80, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h3F, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h10, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'h00, 0, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);
        add_row(8'hFF, 1, 0, 0, ACT_NONE, CODE_IDLE, 0, 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        c = '{ramp_timeout: 24'd3, avalid_warn_ticks: 24'd2, detect_timeout: 24'd2,
              reset_hold_ticks: 24'd2, recovery_ticks: 24'd4, error_retry_ticks: 24'd2};
        load_limits(c);
        foreach (directed_polls[i])
            offer_poll(directed_polls[i].poll, directed_polls[i].fixed,
                       directed_polls[i].want);
        s_tvalid <= 1'b0;
        wait_drained();

        for (k = 0; k < 7; k++) begin
            case (k)
                0: c = {6{24'd1}};
                1: c = '0;
                2: c = {6{24'hFFFFFF}};
                4: begin
                    c = {6{24'd3}};
                    c.reset_hold_ticks = CFG_WIDTH'($urandom_range(4, 9));
                    c.recovery_ticks = CFG_WIDTH'($urandom_range(1, 3));
                end
                5: begin
                    c.ramp_timeout = CFG_WIDTH'($urandom_range(1, 30));
                    c.avalid_warn_ticks = CFG_WIDTH'($urandom_range(1, 30));
                    c.detect_timeout = CFG_WIDTH'($urandom_range(1, 30));
                    c.reset_hold_ticks = CFG_WIDTH'($urandom_range(1, 30));
                    c.recovery_ticks = CFG_WIDTH'($urandom_range(1, 30));
                    c.error_retry_ticks = CFG_WIDTH'($urandom_range(1, 30));
                end
                6: c = '{ramp_timeout: 24'hFFFFFF, avalid_warn_ticks: 24'd1,
                         detect_timeout: CFG_WIDTH'($urandom_range(1, 6)),
                         reset_hold_ticks: 24'd2, recovery_ticks: 24'd5,
                         error_retry_ticks: 24'd3};
                default: begin
                    c.ramp_timeout = CFG_WIDTH'($urandom_range(1, 8));
                    c.avalid_warn_ticks = CFG_WIDTH'($urandom_range(1, 8));
                    c.detect_timeout = CFG_WIDTH'($urandom_range(1, 8));
                    c.reset_hold_ticks = CFG_WIDTH'($urandom_range(1, 8));
                    c.recovery_ticks = CFG_WIDTH'($urandom_range(1, 8));
                    c.error_retry_ticks = CFG_WIDTH'($urandom_range(1, 8));
                end
            endcase
            load_limits(c);
            src_quiet = (k % 3 == 1) || (k == 3);
            dst_quiet = (k % 3 == 2);
            // The sender keeps streaming while the result side holds off.
            if (k == 3)
                hold_burst = 1'b1;
            for (n = 0; n < POLLS_PER_SETTING; n++)
                offer_poll(next_poll(), 1'b0, '0);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d status requests never arrived", status_due.size()));
        if (mismatches == 0)
            $display("[usb_host_attach_sequencer] OK");
        else
            $display("[usb_host_attach_sequencer] ERROR");
        $finish;
    end

endmodule
